FILE: rtl/core/qrs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths, root kind codes and stage records for the root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int CW = 16;                 // coefficient width
	localparam int RF = 16;                 // result fraction bits
	localparam int DW = 2 * CW + 2;         // |D| magnitude width
	localparam int RW = DW + 2 * RF;        // radicand width
	localparam int SW = (RW + 1) / 2;       // square root width
	localparam int NW = CW + RF + 2;        // numerator magnitude width
	localparam int QW = NW;                 // quotient width
	localparam int AW = CW + 1;             // |2a| width

	typedef enum logic [1:0] {
		KIND_DISTINCT = 2'd0,
		KIND_REPEATED = 2'd1,
		KIND_COMPLEX  = 2'd2,
		KIND_DEGEN    = 2'd3
	} root_kind_t;

	// item record carried alongside the root and divide pipelines
	typedef struct packed {
		root_kind_t         kind;
		logic signed [CW:0] den;    // 2a
		logic signed [CW:0] nbi;    // -b as integer
	} qrs_ctl_t;

	// saturate a signed quotient to 32 bits
	function automatic logic [32:0] sat32(input logic neg, input logic [QW-1:0] q);
		logic [QW:0] lim;
		logic [31:0] r;
		logic s;
		lim = neg ? (QW+1)'(33'h080000000) : (QW+1)'(33'h07FFFFFFF);
		s = 1'b0;
		if ({1'b0, q} > lim) begin
			r = neg ? 32'h80000000 : 32'h7FFFFFFF;
			s = 1'b1;
		end else begin
			r = neg ? 32'(-{1'b0, q}) : q[31:0];
		end
		return {s, r};
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/qrs_disc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_disc
// Two-stage discriminant: products, then |b^2-4ac| and root classification.
// ----------------------------------------------------------------------------
module qrs_disc (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire signed [qrs_pkg::CW-1:0] coef_a,
	input  wire signed [qrs_pkg::CW-1:0] coef_b,
	input  wire signed [qrs_pkg::CW-1:0] coef_c,
	output logic                         out_valid,
	output qrs_pkg::qrs_ctl_t            out_ctl,
	output logic [qrs_pkg::DW-1:0]       out_dmag
);
	import qrs_pkg::*;

	logic                   v_s1;
	logic [2*CW-1:0]        b2_s1;
	logic [2*CW-1:0]        ac_s1;
	logic                   acneg_s1, azero_s1;
	logic signed [CW:0]     den_s1, nbi_s1;
	logic [DW-1:0]          b2x, ac4x, dm;
	root_kind_t             kind;
	logic [CW-1:0]          ma, mb, mc;

	assign ma = coef_a[CW-1] ? CW'(-coef_a) : coef_a;
	assign mb = coef_b[CW-1] ? CW'(-coef_b) : coef_b;
	assign mc = coef_c[CW-1] ? CW'(-coef_c) : coef_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		b2_s1    <= mb * mb;
		ac_s1    <= ma * mc;
		acneg_s1 <= (coef_c != '0) && (coef_a[CW-1] != coef_c[CW-1]);
		azero_s1 <= (coef_a == '0);
		den_s1   <= {coef_a, 1'b0};
		nbi_s1   <= -(CW+1)'(coef_b);
	end

	assign b2x  = DW'(b2_s1);
	assign ac4x = {ac_s1, 2'b00};

	always_comb begin
		if (acneg_s1) begin
			dm = b2x + ac4x;
			kind = KIND_DISTINCT;
		end else if (b2x >= ac4x) begin
			dm = b2x - ac4x;
			kind = (dm == '0) ? KIND_REPEATED : KIND_DISTINCT;
		end else begin
			dm = ac4x - b2x;
			kind = KIND_COMPLEX;
		end
		if (azero_s1) begin
			kind = KIND_DEGEN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		out_ctl  <= '{kind: kind, den: den_s1, nbi: nbi_s1};
		out_dmag <= dm;
	end

endmodule
`default_nettype wire

FILE: rtl/core/qrs_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined restoring square root of |D|*2^(2R), one result bit per stage.
// ----------------------------------------------------------------------------
module qrs_sqrt (
	input  wire                     clk,
	input  wire                     arst_n,
	input  wire                     in_valid,
	input  qrs_pkg::qrs_ctl_t       in_ctl,
	input  wire [qrs_pkg::DW-1:0]   in_dmag,
	output logic                    out_valid,
	output qrs_pkg::qrs_ctl_t       out_ctl,
	output logic [qrs_pkg::SW-1:0]  out_root
);
	import qrs_pkg::*;

	localparam int PW = 2 * SW;  // radicand padded to even width

	logic [SW:0]          v_q;
	qrs_ctl_t             ctl_q  [SW+1];
	logic [PW-1:0]        rad_q  [SW+1];
	logic [SW+1:0]        rem_q  [SW+1];
	logic [SW-1:0]        root_q [SW+1];

	assign v_q[0]    = in_valid;
	assign ctl_q[0]  = in_ctl;
	assign rad_q[0]  = PW'({in_dmag, {(2*RF){1'b0}}});
	assign rem_q[0]  = '0;
	assign root_q[0] = '0;

	for (genvar i = 0; i < SW; i++) begin : g_bit
		logic [SW+1:0] trial, rem_n;
		logic          fit;
		always_comb begin
			rem_n = {rem_q[i][SW-1:0], rad_q[i][PW-1:PW-2]};
			trial = {root_q[i], 2'b01};
			fit   = rem_n >= trial;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else begin
				v_q[i+1] <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			ctl_q[i+1]  <= ctl_q[i];
			rad_q[i+1]  <= {rad_q[i][PW-3:0], 2'b00};
			rem_q[i+1]  <= fit ? rem_n - trial : rem_n;
			root_q[i+1] <= {root_q[i][SW-2:0], fit};
		end
	end

	assign out_valid = v_q[SW];
	assign out_ctl   = ctl_q[SW];
	assign out_root  = root_q[SW];

endmodule
`default_nettype wire

FILE: rtl/core/qrs_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div
// Numerator setup, two pipelined restoring dividers and 32-bit saturation.
// ----------------------------------------------------------------------------
module qrs_div (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    in_valid,
	input  qrs_pkg::qrs_ctl_t      in_ctl,
	input  wire [qrs_pkg::SW-1:0]  in_root,
	output logic                   out_valid,
	output logic [1:0]             out_kind,
	output logic signed [31:0]     out_first,
	output logic signed [31:0]     out_second,
	output logic                   out_sat
);
	import qrs_pkg::*;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [NW-1:0] num;
		logic [QW-1:0] q;
		logic          neg;
	} lane_t;

	// setup stage
	logic               v_s1;
	root_kind_t         kind_s1;
	logic [AW-1:0]      dmag_s1;
	lane_t              l0_s1, l1_s1;
	logic signed [NW:0] nb, n0, n1, sx;
	logic               dneg;

	always_comb begin
		nb   = (NW+1)'(in_ctl.nbi) <<< RF;
		sx   = (NW+1)'({1'b0, in_root});
		dneg = in_ctl.den[CW];
		unique case (in_ctl.kind)
			KIND_DISTINCT: begin
				n0 = nb + sx;
				n1 = nb - sx;
			end
			KIND_COMPLEX: begin
				n0 = nb;
				n1 = sx;
			end
			default: begin
				n0 = nb;
				n1 = nb;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		kind_s1 <= in_ctl.kind;
		dmag_s1 <= dneg ? AW'(-in_ctl.den) : AW'(in_ctl.den);
		l0_s1   <= '{rem: '0, num: n0[NW] ? NW'(-n0) : NW'(n0), q: '0,
			neg: n0[NW] != dneg};
		l1_s1   <= '{rem: '0, num: n1[NW] ? NW'(-n1) : NW'(n1), q: '0,
			neg: (in_ctl.kind == KIND_COMPLEX) ? 1'b0 : (n1[NW] != dneg)};
	end

	// one quotient bit per stage for both lanes
	logic [QW:0]   v_q;
	root_kind_t    k_q  [QW+1];
	logic [AW-1:0] d_q  [QW+1];
	lane_t         a_q  [QW+1];
	lane_t         b_q  [QW+1];

	assign v_q[0] = v_s1;
	assign k_q[0] = kind_s1;
	assign d_q[0] = dmag_s1;
	assign a_q[0] = l0_s1;
	assign b_q[0] = l1_s1;

	function automatic lane_t dstep(input lane_t x, input logic [AW-1:0] d);
		lane_t       y;
		logic [NW:0] r;
		y = x;
		r = {x.rem, x.num[NW-1]};
		y.num = {x.num[NW-2:0], 1'b0};
		if (r >= (NW+1)'(d)) begin
			y.rem = NW'(r - (NW+1)'(d));
			y.q   = {x.q[QW-2:0], 1'b1};
		end else begin
			y.rem = NW'(r);
			y.q   = {x.q[QW-2:0], 1'b0};
		end
		return y;
	endfunction

	for (genvar i = 0; i < QW; i++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[i+1] <= 1'b0;
			end else begin
				v_q[i+1] <= v_q[i];
			end
		end
		always_ff @(posedge clk) begin
			k_q[i+1] <= k_q[i];
			d_q[i+1] <= d_q[i];
			a_q[i+1] <= dstep(a_q[i], d_q[i]);
			b_q[i+1] <= dstep(b_q[i], d_q[i]);
		end
	end

	logic [32:0] s0, s1;
	assign s0 = sat32(a_q[QW].neg && a_q[QW].q != '0, a_q[QW].q);
	assign s1 = sat32(b_q[QW].neg && b_q[QW].q != '0, b_q[QW].q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_q[QW];
		end
	end

	always_ff @(posedge clk) begin
		out_kind <= k_q[QW];
		if (k_q[QW] == KIND_DEGEN) begin
			out_first  <= '0;
			out_second <= '0;
			out_sat    <= 1'b0;
		end else begin
			out_first  <= s0[31:0];
			out_second <= s1[31:0];
			out_sat    <= s0[32] | s1[32];
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/quadratic_root_solver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2+b*x+c, Q8.8 coefficients in, Q16.16 roots out.
// ----------------------------------------------------------------------------
// channel  | handshake         | fields
// input    | start (busy = 0)  | coef_a, coef_b, coef_c
// result   | done strobe       | root_kind, first_value, second_value, saturated
//
// One item per cycle. An item passes the discriminant stages, the bitwise root
// stages, the divider setup stage, the quotient stages and the output register.
// busy is always low; the result strobe cannot be held off, so nothing stalls.
// arst_n clears all valid bits; data registers are not reset.
module quadratic_root_solver (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire signed [qrs_pkg::CW-1:0] coef_a,
	input  wire signed [qrs_pkg::CW-1:0] coef_b,
	input  wire signed [qrs_pkg::CW-1:0] coef_c,
	output logic                         done,
	output logic [1:0]                   root_kind,
	output logic signed [31:0]           first_value,
	output logic signed [31:0]           second_value,
	output logic                         saturated
);
	import qrs_pkg::*;

	logic          d_valid, s_valid;
	qrs_ctl_t      d_ctl, s_ctl;
	logic [DW-1:0] d_mag;
	logic [SW-1:0] s_root;

	assign busy = 1'b0;

	qrs_disc u_disc (
		.clk(clk), .arst_n(arst_n), .in_valid(start && !busy),
		.coef_a(coef_a), .coef_b(coef_b), .coef_c(coef_c),
		.out_valid(d_valid), .out_ctl(d_ctl), .out_dmag(d_mag)
	);

	qrs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_valid(d_valid), .in_ctl(d_ctl),
		.in_dmag(d_mag), .out_valid(s_valid), .out_ctl(s_ctl), .out_root(s_root)
	);

	qrs_div u_div (
		.clk(clk), .arst_n(arst_n), .in_valid(s_valid), .in_ctl(s_ctl),
		.in_root(s_root), .out_valid(done), .out_kind(root_kind),
		.out_first(first_value), .out_second(second_value), .out_sat(saturated)
	);

endmodule
`default_nettype wire

FILE: rtl/core/qrs_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_checker
// Port-level checks on the root solver results.
// ----------------------------------------------------------------------------
module qrs_checker (
	input wire               clk,
	input wire               arst_n,
	input wire               busy,
	input wire               done,
	input wire [1:0]         root_kind,
	input wire signed [31:0] first_value,
	input wire signed [31:0] second_value,
	input wire               saturated
);
	import qrs_pkg::*;

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_kind == KIND_DEGEN |-> first_value == 0 && second_value == 0
		&& !saturated) else $error("degenerate item not zero");
	a_repeat_eq: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_kind == KIND_REPEATED |-> first_value == second_value)
		else $error("repeated root differs");
	a_imag_pos: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_kind == KIND_COMPLEX |-> !second_value[31])
		else $error("negative imaginary part");
	// 2*sqrt term is at least 2^17, |2a| at most 2^16, so unclipped roots differ
	a_dist_order: assert property (@(posedge clk) disable iff (!arst_n)
		done && root_kind == KIND_DISTINCT && !saturated |-> first_value != second_value)
		else $error("distinct roots bad");

endmodule

bind quadratic_root_solver qrs_checker u_qrs_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .done(done), .root_kind(root_kind),
	.first_value(first_value), .second_value(second_value), .saturated(saturated)
);
`default_nettype wire
